FILE: rtl/two_class_preferential_queue_unit_defines.svh
// Assertion helpers for the preferential queue unit
`ifndef TWO_CLASS_PREFERENTIAL_QUEUE_UNIT_DEFINES_SVH
`define TWO_CLASS_PREFERENTIAL_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define TCPQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tcpq_pkg.sv
package tcpq_pkg;

   localparam int DEPTH         = 16;
   localparam int ID_WIDTH      = 16;
   localparam int ID_FIELD_W    = 16;
   localparam int COUNT_FIELD_W = 5;
   localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W         = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      OP_INSERT       = 2'd0,
      OP_SERVE_PREF   = 2'd1,
      OP_SERVE_OLDEST = 2'd2,
      OP_WITHDRAW     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0] id;
      logic                pref;
   } entry_type;

   typedef struct packed {
      op_type              op;
      logic [ID_WIDTH-1:0] id;
      logic                pref;
   } req_item_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_entry;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_cmd_type;

   typedef struct packed {
      logic                     ok;
      logic [ID_FIELD_W-1:0]    served_id;
      logic [COUNT_FIELD_W-1:0] total_count;
      logic [COUNT_FIELD_W-1:0] pref_count;
   } result_type;

endpackage

FILE: rtl/tcpq_if.sv
interface tcpq_req_if;
   import tcpq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [1:0]            req_type;
   logic [ID_FIELD_W-1:0] person_id;
   logic                  is_pref;

   modport source (output valid, output req_type, output person_id, output is_pref,
                   input ready);
   modport sink   (input valid, input req_type, input person_id, input is_pref,
                   output ready);
endinterface

interface tcpq_rsp_if;
   import tcpq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     ok;
   logic [ID_FIELD_W-1:0]    served_id;
   logic [COUNT_FIELD_W-1:0] total_count;
   logic [COUNT_FIELD_W-1:0] pref_count;

   modport source (output valid, output ok, output served_id, output total_count,
                   output pref_count, input ready);
   modport sink   (input valid, input ok, input served_id, input total_count,
                   input pref_count, output ready);
endinterface

FILE: rtl/tcpq_mem.sv
module tcpq_mem (
   input  logic                   clock,
   input  tcpq_pkg::mem_cmd_type  mem_cmd,
   output tcpq_pkg::entry_type    rd_entry
);
   import tcpq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_entry_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem[mem_cmd.wr_addr] <= mem_cmd.wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_entry_ff <= mem[mem_cmd.rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

FILE: rtl/tcpq_ctrl.sv
module tcpq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tcpq_pkg::req_item_type req_item,
   output logic                   res_valid,
   input  logic                   res_taken,
   output tcpq_pkg::result_type   res,
   output tcpq_pkg::mem_cmd_type  mem_cmd,
   input  tcpq_pkg::entry_type    rd_entry
);
   import tcpq_pkg::*;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic                pref_ff, pref_in;
   logic [CNT_W-1:0]    addr_ff, addr_in;       // next slot to read
   logic                pend_ff, pend_in;       // read data in flight
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    pref_cnt_ff, pref_cnt_in;
   logic                rm_pref_ff, rm_pref_in;
   logic [ID_WIDTH-1:0] served_ff, served_in;
   logic                ok_ff, ok_in;
   logic                hit;

   // shared compare: does the entry just read satisfy the request
   always_comb begin
      case (op_ff)
         OP_INSERT, OP_WITHDRAW: hit = pend_ff && (rd_entry.id == id_ff);
         OP_SERVE_PREF:          hit = pend_ff && ((pref_cnt_ff == '0) || rd_entry.pref);
         OP_SERVE_OLDEST:        hit = pend_ff;
         default:                hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pend_ff     <= 1'b0;
         count_ff    <= '0;
         pref_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         pend_ff     <= pend_in;
         count_ff    <= count_in;
         pref_cnt_ff <= pref_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      pref_ff     <= pref_in;
      addr_ff     <= addr_in;
      pend_idx_ff <= pend_idx_in;
      rm_pref_ff  <= rm_pref_in;
      served_ff   <= served_in;
      ok_ff       <= ok_in;
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      pref_in     = pref_ff;
      addr_in     = addr_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      count_in    = count_ff;
      pref_cnt_in = pref_cnt_ff;
      rm_pref_in  = rm_pref_ff;
      served_in   = served_ff;
      ok_in       = ok_ff;
      mem_cmd     = '0;
      req_ready   = 1'b0;
      res_valid   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_item.op;
               id_in     = req_item.id;
               pref_in   = req_item.pref;
               addr_in   = '0;
               pend_in   = 1'b0;
               served_in = '0;
               ok_in     = 1'b0;
               state_in  = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (hit) begin
               rm_pref_in = rd_entry.pref;
               pend_in    = 1'b0;
               if (op_ff == OP_INSERT) begin
                  state_in = ST_FINISH;   // duplicate id
               end else begin
                  if (op_ff == OP_SERVE_PREF || op_ff == OP_SERVE_OLDEST) begin
                     served_in = rd_entry.id;
                  end
                  addr_in  = CNT_W'(pend_idx_ff) + CNT_W'(1);
                  state_in = ST_SHIFT;
               end
            end else if (addr_ff < count_ff) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = addr_ff[IDX_W-1:0];
               pend_in         = 1'b1;
               pend_idx_in     = addr_ff[IDX_W-1:0];
               addr_in         = addr_ff + CNT_W'(1);
            end else begin
               // whole list checked without a match
               pend_in = 1'b0;
               if (op_ff == OP_INSERT && count_ff < CNT_W'(DEPTH)) begin
                  mem_cmd.wr_en         = 1'b1;
                  mem_cmd.wr_addr       = count_ff[IDX_W-1:0];
                  mem_cmd.wr_entry.id   = id_ff;
                  mem_cmd.wr_entry.pref = pref_ff;
                  count_in              = count_ff + CNT_W'(1);
                  pref_cnt_in           = pref_cnt_ff + CNT_W'(pref_ff);
                  ok_in                 = 1'b1;
               end
               state_in = ST_FINISH;
            end
         end

         ST_SHIFT: begin
            // entry read last cycle moves down one slot
            if (pend_ff) begin
               mem_cmd.wr_en    = 1'b1;
               mem_cmd.wr_addr  = pend_idx_ff - IDX_W'(1);
               mem_cmd.wr_entry = rd_entry;
            end
            if (addr_ff < count_ff) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = addr_ff[IDX_W-1:0];
               pend_in         = 1'b1;
               pend_idx_in     = addr_ff[IDX_W-1:0];
               addr_in         = addr_ff + CNT_W'(1);
            end else begin
               pend_in     = 1'b0;
               count_in    = count_ff - CNT_W'(1);
               pref_cnt_in = pref_cnt_ff - CNT_W'(rm_pref_ff);
               ok_in       = 1'b1;
               state_in    = ST_FINISH;
            end
         end

         ST_FINISH: begin
            res_valid = 1'b1;
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res.ok          = ok_ff;
   assign res.served_id   = ID_FIELD_W'(served_ff);
   assign res.total_count = COUNT_FIELD_W'(count_ff);
   assign res.pref_count  = COUNT_FIELD_W'(pref_cnt_ff);

endmodule

FILE: rtl/two_class_preferential_queue_unit.sv
// Operation: a request is taken while idle; the id store is scanned oldest first
//   to a match or to the end of the list; a serve or a successful withdraw then
//   closes up the later entries by one slot, and a finish state hands on the result.
// Requests: one at a time, through the single compare unit and the one read / one
//   write port of the id store; the next is taken once the result has moved on.
// Reset: synchronous; clears counts and control; id store is not cleared.
`include "two_class_preferential_queue_unit_defines.svh"

module two_class_preferential_queue_unit (
   input logic        clock,
   input logic        reset,
   tcpq_req_if.sink   req_ch,
   tcpq_rsp_if.source rsp_ch
);
   import tcpq_pkg::*;

   req_item_type req_item;
   result_type   res;
   mem_cmd_type  mem_cmd;
   entry_type    rd_entry;
   logic         res_valid;
   logic         res_taken;

   // result register; the next request may enter while a result waits here
   logic         rsp_valid_ff, rsp_valid_in;
   result_type   rsp_data_ff;

   // terms for the checks at the end
   logic         req_xfer;
   logic         counts_ok;
   logic         rsp_fail;
   logic         no_served;

   // only the low ID_WIDTH bits of the id take part
   assign req_item.op   = op_type'(req_ch.req_type);
   assign req_item.id   = req_ch.person_id[ID_WIDTH-1:0];
   assign req_item.pref = req_ch.is_pref;

   tcpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_item  (req_item),
      .res_valid (res_valid),
      .res_taken (res_taken),
      .res       (res),
      .mem_cmd   (mem_cmd),
      .rd_entry  (rd_entry)
   );

   tcpq_mem u_mem (
      .clock    (clock),
      .mem_cmd  (mem_cmd),
      .rd_entry (rd_entry)
   );

   // load the result register when it is empty or being drained this cycle
   assign res_taken    = res_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign rsp_valid_in = res_taken || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_taken) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.ok          = rsp_data_ff.ok;
   assign rsp_ch.served_id   = rsp_data_ff.served_id;
   assign rsp_ch.total_count = rsp_data_ff.total_count;
   assign rsp_ch.pref_count  = rsp_data_ff.pref_count;

   assign req_xfer  = req_ch.valid && req_ch.ready;
   assign counts_ok = (rsp_ch.pref_count <= rsp_ch.total_count) &&
                      (rsp_ch.total_count <= COUNT_FIELD_W'(DEPTH));
   assign rsp_fail  = rsp_ch.valid && !rsp_ch.ok;
   assign no_served = (rsp_ch.served_id == '0);

   // one request at a time: busy right after a transfer
   `TCPQ_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, !req_ch.ready, "taken while busy")
   // preferential ids are a subset of the list, list never exceeds depth
   `TCPQ_ASSERT_IMPL(a_counts_bounded, clock, reset, rsp_ch.valid, counts_ok, "bad count")
   // a failed request never reports a served id
   `TCPQ_ASSERT_IMPL(a_fail_no_id, clock, reset, rsp_fail, no_served, "served id on failure")

endmodule

FILE: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcpq_pkg::*;

   // One request as queued for the driver. drain_first holds the request back
   // until every result already owed has been transferred.
   typedef struct {
      op_type                op;
      logic [ID_FIELD_W-1:0] person_id;
      logic                  is_pref;
      bit                    drain_first;
   } pending_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcpq_req_if req_ch();
   tcpq_rsp_if rsp_ch();

   two_class_preferential_queue_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow copy of the queue contents, oldest entry in slot 0
   // ---------------------------------------------------------------------
   logic [ID_WIDTH-1:0] held_ids [DEPTH];
   bit                  held_pref[DEPTH];
   int unsigned         held_total      = 0;
   int unsigned         held_pref_total = 0;

   pending_req_type pending_requests[$];
   result_type      awaited_results[$];

   int          failures  = 0;
   bit          req_taken = 1'b0;   // request transfer seen at the last rising edge
   int unsigned req_gap   = 0;
   int unsigned req_calm  = 0;
   int unsigned rsp_stall = 0;
   int unsigned rsp_calm  = 0;

   // Remove one slot and close up the later entries behind it.
   function automatic void drop_slot(int unsigned slot);
      if (held_pref[slot] && held_pref_total > 0)
         held_pref_total--;
      for (int unsigned i = slot; i + 1 < held_total; i++) begin
         held_ids[i]  = held_ids[i + 1];
         held_pref[i] = held_pref[i + 1];
      end
      held_total--;
   endfunction

   // Apply one request to the shadow queue and return the result it owes.
   function automatic result_type service_request(op_type op,
                                                  logic [ID_FIELD_W-1:0] person_id,
                                                  logic is_pref);
      result_type          r;
      logic [ID_WIDTH-1:0] id;
      int unsigned         slot;
      bit                  found;
      r     = '0;
      id    = person_id[ID_WIDTH-1:0];   // bits above the id width are ignored
      found = 1'b0;
      slot  = 0;
      if (op == OP_INSERT || op == OP_WITHDRAW) begin
         for (int unsigned i = 0; i < held_total; i++) begin
            if (!found && held_ids[i] == id) begin
               found = 1'b1;
               slot  = i;
            end
         end
      end
      case (op)
         OP_INSERT: begin
            // duplicate id or full queue: rejected, nothing changes
            if (!found && held_total < DEPTH) begin
               held_ids[held_total]  = id;
               held_pref[held_total] = is_pref;
               held_total++;
               if (is_pref)
                  held_pref_total++;
               r.ok = 1'b1;
            end
         end
         OP_SERVE_PREF, OP_SERVE_OLDEST: begin
            // empty queue: ok stays low, served id stays zero
            if (held_total > 0) begin
               // preferential serve falls back to the oldest id when no
               // preferential id is held
               if (op == OP_SERVE_PREF && held_pref_total > 0) begin
                  while (slot + 1 < held_total && !held_pref[slot])
                     slot++;
               end
               r.served_id = ID_FIELD_W'(held_ids[slot]);
               drop_slot(slot);
               r.ok = 1'b1;
            end
         end
         OP_WITHDRAW: begin
            if (found) begin
               drop_slot(slot);
               r.ok = 1'b1;
            end
         end
      endcase
      r.total_count = COUNT_FIELD_W'(held_total);
      r.pref_count  = COUNT_FIELD_W'(held_pref_total);
      return r;
   endfunction

   // Idle length for either side: mostly zero or short, a few long, and now
   // and then a calm stretch with no idling at all.
   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if (roll < 2) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_request(op_type op, logic [ID_FIELD_W-1:0] person_id,
                                       logic is_pref, bit drain_first);
      pending_req_type p;
      p.op          = op;
      p.person_id   = person_id;
      p.is_pref     = is_pref;
      p.drain_first = drain_first;
      pending_requests.push_back(p);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: changes at the falling edge, holds a request until its
   // transfer, then idles for a random gap before the next one.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      pending_req_type next_req;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_requests.size() == 0 ||
                      (pending_requests[0].drain_first && awaited_results.size() != 0)) begin
            // nothing left, or holding off until the block has drained
            req_ch.valid <= 1'b0;
         end else begin
            next_req = pending_requests.pop_front();
            req_ch.req_type  <= next_req.op;
            req_ch.person_id <= next_req.person_id;
            req_ch.is_pref   <= next_req.is_pref;
            req_ch.valid     <= 1'b1;
            req_gap = pick_gap(req_calm);
         end
      end
   end

   // Result side back-pressure, also changed at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 2) == 0)
            rsp_stall = pick_gap(rsp_calm);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: samples both channels at the rising edge. The result transfer
   // is checked before a request in the same cycle is predicted, so ordering
   // holds even if a stray result shows up.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               $error("result transfer with no request outstanding");
               failures++;
            end else begin
               want = awaited_results.pop_front();
               check_field("ok",          32'(want.ok),          32'(rsp_ch.ok));
               check_field("served_id",   32'(want.served_id),   32'(rsp_ch.served_id));
               check_field("total_count", 32'(want.total_count), 32'(rsp_ch.total_count));
               check_field("pref_count",  32'(want.pref_count),  32'(rsp_ch.pref_count));
            end
         end
         if (req_ch.valid && req_ch.ready)
            awaited_results.push_back(service_request(op_type'(req_ch.req_type),
                                                      req_ch.person_id, req_ch.is_pref));
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      logic [ID_FIELD_W-1:0] id_pool[20];
      logic [ID_FIELD_W-1:0] id;
      op_type                op;
      int                    roll;
      int                    ins_weight;

      req_ch.valid     = 1'b0;
      req_ch.req_type  = OP_INSERT;
      req_ch.person_id = '0;
      req_ch.is_pref   = 1'b0;
      rsp_ch.ready     = 1'b0;

      // directed: both serves on an empty queue
      add_request(OP_SERVE_PREF,   16'h0000, 1'b1, 1'b0);
      add_request(OP_SERVE_OLDEST, 16'hFFFF, 1'b1, 1'b0);
      // id extremes, duplicate insert, preferential id behind a general one
      add_request(OP_INSERT,       16'h0000, 1'b0, 1'b0);
      add_request(OP_INSERT,       16'hFFFF, 1'b1, 1'b0);
      add_request(OP_INSERT,       16'h0000, 1'b1, 1'b0);
      add_request(OP_SERVE_PREF,   16'h1234, 1'b0, 1'b0);
      // no preferential id left: falls back to the oldest
      add_request(OP_SERVE_PREF,   16'h0000, 1'b0, 1'b0);
      // fill to capacity with distinct ids, then one insert too many
      add_request(OP_INSERT,       16'hFFFF, 1'b0, 1'b0);
      for (int k = 0; k < 15; k++)
         add_request(OP_INSERT, (k[0] ? 16'hAAAA : 16'h5555) ^ 16'(k), k[1], 1'b0);
      add_request(OP_INSERT,       16'h1234, 1'b1, 1'b1);
      // withdraw from the middle, serves on the remaining entries, absent withdraw
      add_request(OP_WITHDRAW,     16'h5555 ^ 16'd6, 1'b0, 1'b0);
      add_request(OP_SERVE_OLDEST, 16'h0000, 1'b0, 1'b0);
      add_request(OP_SERVE_PREF,   16'h0000, 1'b0, 1'b0);
      add_request(OP_WITHDRAW,     16'h0000, 1'b1, 1'b0);

      // random phases: each one draws ids mostly from a small pool so that
      // duplicates and successful withdraws are common, and tilts the mix
      // toward filling or draining the queue
      for (int phase = 0; phase < 17; phase++) begin
         foreach (id_pool[i])
            id_pool[i] = ID_FIELD_W'($urandom_range(0, 65535));
         if (phase % 3 == 0) begin
            id_pool[0] = 16'h0000;
            id_pool[1] = 16'hFFFF;
         end
         ins_weight = $urandom_range(25, 75);
         for (int k = 0; k < 100; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_weight)
               op = OP_INSERT;
            else if (roll < ins_weight + (100 - ins_weight) / 3)
               op = OP_SERVE_PREF;
            else if (roll < ins_weight + 2 * (100 - ins_weight) / 3)
               op = OP_WITHDRAW;
            else
               op = OP_SERVE_OLDEST;
            if ($urandom_range(0, 9) < 8)
               id = id_pool[$urandom_range(0, 19)];
            else
               id = ID_FIELD_W'($urandom_range(0, 65535));
            add_request(op, id, 1'($urandom_range(0, 1)), k == 0 && phase % 4 == 1);
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for the last request transfer and its result, then let the
      // worst-case latency pass so a stray result would still be caught
      while (pending_requests.size() != 0 || req_ch.valid || awaited_results.size() != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // watchdog
   initial begin
      #(12_000_000);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
